// ===== rtl/core/hsl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg
// shared widths, constants and operand type of the rgb to hsl converter
// ----------------------------------------------------------------------------
package hsl_pkg;

    // color component and sum widths
    localparam int COMP_W = 8;
    localparam int SUM_W  = COMP_W + 1;

    // divider operand width: holds 6 * (max - min) = 1530
    localparam int DIV_W = 11;

    // quotient width, unsigned q0.16
    localparam int Q_W = 16;

    // divider lanes, one quotient each
    localparam int LANES     = 3;
    localparam int LANE_HUE  = 0;
    localparam int LANE_SAT  = 1;
    localparam int LANE_LGT  = 2;

    // largest component and largest max + min
    localparam logic [COMP_W-1:0] COMP_MAX = 8'd255;
    localparam logic [SUM_W-1:0]  SUM_MAX  = 9'd510;

    // one divider lane: num <= den, quotient floor(num * 2^q_w / den), 1.0 -> all ones
    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_op;

endpackage

// ===== rtl/core/hsl_div_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_div_pipe
// pipelined restoring divider, several lanes in lockstep, fractional quotient
// ----------------------------------------------------------------------------
module hsl_div_pipe #(
    parameter int STEPS_PER_STAGE = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  hsl_pkg::t_div_op           i_op [hsl_pkg::LANES],
    input  logic                       i_side,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hsl_pkg::Q_W-1:0]    o_quo [hsl_pkg::LANES],
    output logic                       o_side
);

    localparam int DW   = hsl_pkg::DIV_W;
    localparam int QW   = hsl_pkg::Q_W;
    localparam int LN   = hsl_pkg::LANES;
    localparam int NSTG = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    logic            r_vld  [NSTG];
    logic            r_side [NSTG];
    logic [DW-1:0]   r_rem  [NSTG][LN];
    logic [DW-1:0]   r_den  [NSTG][LN];
    logic [QW-1:0]   r_quo  [NSTG][LN];
    logic            w_open [NSTG];

    assign o_ready = w_open[0];

    for (genvar j = 0; j < NSTG; j++) begin : g_stg
        logic            src_vld;
        logic            src_side;
        logic [DW-1:0]   src_rem [LN];
        logic [DW-1:0]   src_den [LN];
        logic [QW-1:0]   src_quo [LN];
        logic [DW-1:0]   n_rem   [LN];
        logic [QW-1:0]   n_quo   [LN];

        // stage slot is free or its word moves on this cycle
        if (j == NSTG - 1) begin : g_last
            assign w_open[j] = !r_vld[j] || i_ready;
        end else begin : g_mid
            assign w_open[j] = !r_vld[j] || w_open[j+1];
        end

        if (j == 0) begin : g_src_in
            always_comb begin
                src_vld  = i_valid;
                src_side = i_side;
                for (int l = 0; l < LN; l++) begin
                    src_rem[l] = i_op[l].num;
                    src_den[l] = i_op[l].den;
                    src_quo[l] = '0;
                end
            end
        end else begin : g_src_prev
            always_comb begin
                src_vld  = r_vld[j-1];
                src_side = r_side[j-1];
                for (int l = 0; l < LN; l++) begin
                    src_rem[l] = r_rem[j-1][l];
                    src_den[l] = r_den[j-1][l];
                    src_quo[l] = r_quo[j-1][l];
                end
            end
        end

        // shift, compare, subtract: one quotient bit per step
        always_comb begin
            logic [DW:0]   t;
            logic [DW-1:0] rem;
            logic [QW-1:0] quo;
            logic          qbit;
            for (int l = 0; l < LN; l++) begin
                rem = src_rem[l];
                quo = src_quo[l];
                for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                    if (j * STEPS_PER_STAGE + k < QW) begin
                        t = {rem, 1'b0};
                        if (t >= {1'b0, src_den[l]}) begin
                            t    = t - {1'b0, src_den[l]};
                            qbit = 1'b1;
                        end else begin
                            qbit = 1'b0;
                        end
                        rem = t[DW-1:0];
                        quo = {quo[QW-2:0], qbit};
                    end
                end
                n_rem[l] = rem;
                n_quo[l] = quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (w_open[j]) begin
                r_vld[j] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_open[j]) begin
                r_side[j] <= src_side;
                for (int l = 0; l < LN; l++) begin
                    r_rem[j][l] <= n_rem[l];
                    r_den[j][l] <= src_den[l];
                    r_quo[j][l] <= n_quo[l];
                end
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_side  = r_side[NSTG-1];

    always_comb begin
        for (int l = 0; l < LN; l++) begin
            o_quo[l] = r_quo[NSTG-1][l];
        end
    end

`ifndef SYNTHESIS
    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted word missing from first divider stage");

    for (genvar j = 0; j < NSTG; j++) begin : g_chk
        // a blocked stage keeps its word
        a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_vld[j] && !w_open[j]) |=> r_vld[j])
            else $error("blocked divider stage dropped its word");

        for (genvar l = 0; l < LN; l++) begin : g_lane
            // partial remainder never passes the divisor
            a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_vld[j] |-> (r_rem[j][l] <= r_den[j][l]))
                else $error("divider remainder above divisor");
        end
    end
`endif

endmodule

// ===== rtl/core/rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps
// throughput: one pixel per cycle unless the output stalls; one operand stage, then a divider
//   pipeline of STEPS_PER_STAGE restoring steps per stage, three lanes side by side
// a stalled output holds the pipe stage by stage, empty stages still fill from the input
// reset: synchronous, active low, clears the valid bits only, no state beyond the pipe
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// 8-bit rgb pixel to hue, saturation and lightness as unsigned q0.16 fractions
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter #(
    parameter int STEPS_PER_STAGE = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input word
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hsl_pkg::COMP_W-1:0]    i_red,
    input  logic [hsl_pkg::COMP_W-1:0]    i_green,
    input  logic [hsl_pkg::COMP_W-1:0]    i_blue,
    // hsl output word
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hsl_pkg::Q_W-1:0]       o_hue,
    output logic [hsl_pkg::Q_W-1:0]       o_saturation,
    output logic [hsl_pkg::Q_W-1:0]       o_lightness,
    output logic                          o_achromatic
);

    localparam int DW = hsl_pkg::DIV_W;
    localparam int CW = hsl_pkg::COMP_W;
    localparam int SW = hsl_pkg::SUM_W;
    localparam int LN = hsl_pkg::LANES;

    // operand stage
    logic                 r_s0_vld;
    logic                 r_s0_achro;
    hsl_pkg::t_div_op     r_s0_op [LN];
    hsl_pkg::t_div_op     n_s0_op [LN];
    logic                 n_s0_achro;
    logic                 w_s0_open;

    // divider handshake and results
    logic                 w_div_ready;
    logic [hsl_pkg::Q_W-1:0] w_quo [LN];

    // first stage advances when empty or when the divider takes its word
    assign w_s0_open = !r_s0_vld || w_div_ready;
    assign o_ready   = w_s0_open;

    // max, min, sector numerator and the three divisions to run
    always_comb begin
        logic [CW-1:0] mx;
        logic [CW-1:0] mn;
        logic [CW-1:0] d;
        logic [SW-1:0] s;
        logic [DW-1:0] r11;
        logic [DW-1:0] g11;
        logic [DW-1:0] b11;
        logic [DW-1:0] d11;
        logic [DW-1:0] d6;
        logic [DW-1:0] n;
        logic [DW-1:0] sden;

        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;

        d   = mx - mn;
        s   = SW'(mx) + SW'(mn);
        r11 = DW'(i_red);
        g11 = DW'(i_green);
        b11 = DW'(i_blue);
        d11 = DW'(d);
        d6  = (d11 << 2) + (d11 << 1);

        // hue sector, ties go red, then green, then blue; wrap kept nonnegative
        if (mx == i_red) begin
            if (i_green < i_blue) begin
                n = d6 - (b11 - g11);
            end else begin
                n = g11 - b11;
            end
        end else if (mx == i_green) begin
            n = (d11 << 1) + b11 - r11;
        end else begin
            n = (d11 << 2) + r11 - g11;
        end

        // saturation divisor folds around the midpoint
        if (s > SW'(hsl_pkg::COMP_MAX)) begin
            sden = DW'(hsl_pkg::SUM_MAX - s);
        end else begin
            sden = DW'(s);
        end

        n_s0_achro = (d == '0);

        // gray pixel: zero over full-scale divisor gives zero hue and saturation
        if (n_s0_achro) begin
            n_s0_op[hsl_pkg::LANE_HUE].num = '0;
            n_s0_op[hsl_pkg::LANE_HUE].den = '1;
            n_s0_op[hsl_pkg::LANE_SAT].num = '0;
            n_s0_op[hsl_pkg::LANE_SAT].den = '1;
        end else begin
            n_s0_op[hsl_pkg::LANE_HUE].num = n;
            n_s0_op[hsl_pkg::LANE_HUE].den = d6;
            n_s0_op[hsl_pkg::LANE_SAT].num = d11;
            n_s0_op[hsl_pkg::LANE_SAT].den = sden;
        end

        // lightness is (max + min) / 510, white comes out all ones
        n_s0_op[hsl_pkg::LANE_LGT].num = DW'(s);
        n_s0_op[hsl_pkg::LANE_LGT].den = DW'(hsl_pkg::SUM_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_s0_open) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_open) begin
            r_s0_achro <= n_s0_achro;
            for (int l = 0; l < LN; l++) begin
                r_s0_op[l] <= n_s0_op[l];
            end
        end
    end

    // three quotients in lockstep, achromatic flag rides along
    hsl_div_pipe #(
        .STEPS_PER_STAGE (STEPS_PER_STAGE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_vld),
        .o_ready (w_div_ready),
        .i_op    (r_s0_op),
        .i_side  (r_s0_achro),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_quo   (w_quo),
        .o_side  (o_achromatic)
    );

    assign o_hue        = w_quo[hsl_pkg::LANE_HUE];
    assign o_saturation = w_quo[hsl_pkg::LANE_SAT];
    assign o_lightness  = w_quo[hsl_pkg::LANE_LGT];

`ifndef SYNTHESIS
    // gray pixels carry zero hue and saturation
    a_achro_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_achromatic) |-> ((o_hue == '0) && (o_saturation == '0)))
        else $error("achromatic word with nonzero hue or saturation");

    // a colored pixel always has some saturation
    a_color_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_achromatic) |-> (o_saturation != '0))
        else $error("colored word with zero saturation");

    // operand stage keeps its word while the divider is blocked
    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s0_vld && !w_div_ready) |=> (r_s0_vld && $stable(r_s0_achro)))
        else $error("operand stage lost its word under stall");
`endif

endmodule
